// File: sv/rgbhsi_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsi_pkg
// Shared constants, pipeline stage record and small arithmetic helpers for
// the rgb to hsi converter.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

    // channel format
    localparam int CHANNEL_BITS = 8;
    localparam int SUM_W        = CHANNEL_BITS + 2;
    localparam int FULL_SCALE   = (2 ** CHANNEL_BITS) - 1;
    localparam int INT_DIV      = 6 * FULL_SCALE;
    localparam int INT_LOW      = 3 * FULL_SCALE;
    localparam int DIV_W        = SUM_W + 2;
    localparam int Q_W          = 16;

    // intensity by reciprocal multiply, exact for numerators below 2^INT_N_W
    localparam int INT_N_W   = SUM_W + 16;
    localparam int INT_SHIFT = INT_N_W + $clog2(INT_DIV);
    localparam int RECIP_W   = INT_N_W + 1;
    localparam int IPROD_W   = INT_N_W + RECIP_W;
    localparam logic [RECIP_W-1:0] INT_RECIP =
        RECIP_W'(((64'd1 << INT_SHIFT) + 64'(INT_DIV) - 64'd1) / 64'(INT_DIV));

    // cordic datapath
    localparam int XY_W          = 29;
    localparam int ANG_W         = 28;
    localparam int CORDIC_STEPS  = 24;
    localparam int DIV_STEPS     = 16;
    localparam int PRE_STAGES    = 3;
    localparam int LAST_STAGE    = PRE_STAGES + CORDIC_STEPS - 1;

    localparam logic [17:0]             SQRT3_Q16   = 18'd113512;
    localparam logic signed [ANG_W-1:0] ANG_PI_HALF = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
    localparam logic [15:0]             HUE_PI      = 16'd25736;
    localparam logic [15:0]             HUE_TWO_PI  = 16'd51472;
    localparam logic [16:0]             SAT_ONE     = 17'd32768;

    // config port
    localparam int OFFSET_W = 17;
    localparam int ADDR_W   = 2;
    localparam logic [ADDR_W-1:0] ADDR_SAT_OFFSET = 2'd0;

    typedef struct packed {
        logic signed [XY_W-1:0]         x;
        logic signed [XY_W-1:0]         y;
        logic signed [ANG_W-1:0]        ang;
        logic signed [CHANNEL_BITS+1:0] dx;
        logic [CHANNEL_BITS-1:0]        dgb;
        logic                           bgt;
        logic                           yzero;
        logic                           dxneg;
        logic                           zsum;
        logic [SUM_W-1:0]               sum;
        logic [SUM_W-1:0]               mn3;
        logic [DIV_W-1:0]               srem;
        logic [Q_W-1:0]                 sq;
        logic [Q_W-1:0]                 iq;
    } pipe_t;

    // atan(2^-i) in signed Q4.24, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_val(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one restoring division step: shift in a numerator bit, subtract if it fits
    function automatic logic [DIV_W:0] div_step(
        input logic [DIV_W-1:0] rem,
        input logic             nbit,
        input logic [DIV_W-1:0] den
    );
        logic [DIV_W-1:0] sh;
        logic             fit;
        sh  = {rem[DIV_W-2:0], nbit};
        fit = (sh >= den);
        return {fit, fit ? (sh - den) : sh};
    endfunction

endpackage

// File: sv/rgbhsi_pipe.sv
// ----------------------------------------------------------------------------
// rgbhsi_pipe
// Front end, 24 cordic vectoring stages and a 16-step restoring divider for
// saturation, one register stage per step, all moving under a common enable.
// Intensity comes from a reciprocal multiply in the seed stage.
// ----------------------------------------------------------------------------
module rgbhsi_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    output logic                              last_valid,
    output rgbhsi_pkg::pipe_t                 last_st
);
    import rgbhsi_pkg::*;

    pipe_t st_reg   [LAST_STAGE+1];
    pipe_t st_next  [LAST_STAGE+1];
    logic  vld_reg  [LAST_STAGE+1];

    logic [CHANNEL_BITS-1:0]  r_c, g_c, b_c, mn_c;
    logic [SUM_W-1:0]         sum_c;
    logic signed [CHANNEL_BITS+1:0] dx_c, dgb_s;
    logic [INT_N_W-1:0]       inum_c;
    logic [IPROD_W-1:0]       iprod_c;

    // stage 0: differences, sum and minimum
    always_comb
    begin
        r_c   = red[CHANNEL_BITS-1:0];
        g_c   = green[CHANNEL_BITS-1:0];
        b_c   = blue[CHANNEL_BITS-1:0];
        sum_c = SUM_W'(r_c) + SUM_W'(g_c) + SUM_W'(b_c);
        mn_c  = r_c;
        if (g_c < mn_c)
        begin
            mn_c = g_c;
        end
        if (b_c < mn_c)
        begin
            mn_c = b_c;
        end
        dx_c  = $signed({2'b00, r_c}) + $signed({2'b00, r_c})
              - $signed({2'b00, g_c}) - $signed({2'b00, b_c});
        dgb_s = $signed({2'b00, g_c}) - $signed({2'b00, b_c});

        st_next[0]       = '0;
        st_next[0].dx    = dx_c;
        st_next[0].dgb   = dgb_s[CHANNEL_BITS+1] ? CHANNEL_BITS'(-dgb_s)
                                                 : CHANNEL_BITS'(dgb_s);
        st_next[0].bgt   = (b_c > g_c);
        st_next[0].yzero = (g_c == b_c);
        st_next[0].dxneg = dx_c[CHANNEL_BITS+1];
        st_next[0].zsum  = (sum_c == '0);
        st_next[0].sum   = sum_c;
        st_next[0].mn3   = SUM_W'(mn_c) + SUM_W'(mn_c) + SUM_W'(mn_c);
    end

    // stage 1: scale the vector, seed the divider, intensity by reciprocal
    always_comb
    begin
        inum_c  = {st_reg[0].sum, 16'd0} + INT_N_W'(INT_LOW);
        iprod_c = IPROD_W'(inum_c) * IPROD_W'(INT_RECIP);

        st_next[1]      = st_reg[0];
        st_next[1].x    = XY_W'(st_reg[0].dx) <<< 16;
        st_next[1].y    = $signed(XY_W'({10'd0, st_reg[0].dgb} * SQRT3_Q16));
        st_next[1].srem = DIV_W'(st_reg[0].mn3);
        st_next[1].sq   = '0;
        st_next[1].iq   = Q_W'(iprod_c >> INT_SHIFT);
    end

    // stage 2: turn a left half-plane vector by -pi/2
    always_comb
    begin
        st_next[2] = st_reg[1];
        if (st_reg[1].x < 0)
        begin
            st_next[2].x   = st_reg[1].y;
            st_next[2].y   = -st_reg[1].x;
            st_next[2].ang = ANG_PI_HALF;
        end
        else
        begin
            st_next[2].ang = '0;
        end
    end

    // cordic and divider stages
    for (genvar k = PRE_STAGES; k <= LAST_STAGE; k++)
    begin : g_step
        localparam int I = k - PRE_STAGES;
        logic signed [XY_W-1:0] xs, ys;
        logic [DIV_W:0]         sres;
        logic [Q_W-1:0]         slow;

        always_comb
        begin
            st_next[k] = st_reg[k-1];
            xs = st_reg[k-1].x >>> I;
            ys = st_reg[k-1].y >>> I;
            if (st_reg[k-1].y > 0)
            begin
                st_next[k].x   = st_reg[k-1].x + ys;
                st_next[k].y   = st_reg[k-1].y - xs;
                st_next[k].ang = st_reg[k-1].ang + atan_val(I);
            end
            else
            begin
                st_next[k].x   = st_reg[k-1].x - ys;
                st_next[k].y   = st_reg[k-1].y + xs;
                st_next[k].ang = st_reg[k-1].ang - atan_val(I);
            end
            slow = Q_W'(st_reg[k-1].sum);
            sres = '0;
            if (I < DIV_STEPS)
            begin
                sres = div_step(st_reg[k-1].srem,
                                slow[(DIV_STEPS-1-I+Q_W) % Q_W],
                                DIV_W'({st_reg[k-1].sum, 1'b0}));
                st_next[k].srem = sres[DIV_W-1:0];
                st_next[k].sq   = {st_reg[k-1].sq[Q_W-2:0], sres[DIV_W]};
            end
        end
    end

    // stage registers and valid bits
    for (genvar s = 0; s <= LAST_STAGE; s++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign last_valid = vld_reg[LAST_STAGE];
    assign last_st    = st_reg[LAST_STAGE];

endmodule

// File: sv/rgb_to_hsi_with_saturation_offset_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_with_saturation_offset_unit
// Converts one rgb pixel per clock to hue (Q3.13 radians), saturation and
// intensity (Q1.15), with a programmable signed saturation offset.
//
//   channel   direction  signals
//   pixel in  in         in_valid / in_ready, red, green, blue
//   hsi out   out        out_valid / out_ready, hue, saturation, intensity
//   config    apb        psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One pixel per clock sustained while results are taken; 28 register stages:
// one input stage, two setup stages, 24 cordic stages and the output register.
// The whole pipeline moves on one enable, held while the output register is
// full and not taken, so a stall loses nothing. Reset clears the valid bits
// and the offset register.
// ----------------------------------------------------------------------------
module rgb_to_hsi_with_saturation_offset_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   hue,
    output logic [15:0]                   saturation,
    output logic [15:0]                   intensity,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbhsi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rgbhsi_pkg::*;

    logic                       en;
    logic                       last_valid;
    pipe_t                      last_st;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       out_valid_reg;
    logic [15:0]                hue_reg, sat_reg, int_reg;
    logic [15:0]                hue_next, sat_next, int_next;

    logic signed [ANG_W-1:0]    ang_c;
    logic signed [ANG_W-1:0]    ang_r;
    logic [15:0]                th;
    logic [16:0]                base;
    logic signed [18:0]         sat_sum;

    // pipeline advances whenever the output register can take a result
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    rgbhsi_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_valid (last_valid),
        .last_st    (last_st)
    );

    // config register
    assign pready = 1'b1;
    assign prdata = 32'(offset_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_SAT_OFFSET))
        begin
            offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    // hue: clamp angle, round to Q3.13, set 0 or pi when green equals blue, mirror when blue exceeds green
    always_comb
    begin
        ang_c = last_st.ang;
        if (ang_c < 0)
        begin
            ang_c = '0;
        end
        if (ang_c > ANG_PI)
        begin
            ang_c = ANG_PI;
        end
        ang_r = (ang_c + 28'sd1024) >>> 11;
        th    = (ang_r[16:0] > 17'(HUE_PI)) ? HUE_PI : ang_r[15:0];
        if (last_st.yzero)
        begin
            th = last_st.dxneg ? HUE_PI : 16'd0;
        end
        hue_next = last_st.bgt ? (HUE_TWO_PI - th) : th;
    end

    // saturation: base plus offset, clamped to [0, 1]; intensity passed through
    always_comb
    begin
        base    = last_st.zsum ? 17'd0 : (SAT_ONE - 17'(last_st.sq));
        sat_sum = $signed({2'b00, base}) + 19'(offset_reg);
        if (sat_sum < 0)
        begin
            sat_next = 16'd0;
        end
        else if (sat_sum > $signed({2'b00, SAT_ONE}))
        begin
            sat_next = SAT_ONE[15:0];
        end
        else
        begin
            sat_next = sat_sum[15:0];
        end
        int_next = last_st.iq;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            int_reg <= int_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign intensity  = int_reg;

endmodule

// File: sim/rgb_to_hsi_with_saturation_offset_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_with_saturation_offset_unit_tb
// Drives random and corner pixels through the converter under several
// handshake idling phases and offset settings, predicts hue, saturation and
// intensity per pixel and compares every output transfer in order.
// ----------------------------------------------------------------------------
module rgb_to_hsi_with_saturation_offset_unit_tb;

    import rgbhsi_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] i;
    } hsi_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic out_valid;
    logic out_ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] intensity;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pixel_t pixel_queue[$];
    hsi_t   hsi_expected[$];
    longint offset_val;
    int     err_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_send;
    bit     in_fire;

    rgb_to_hsi_with_saturation_offset_unit uut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor shift of a signed value
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    // theta in q3.13 from cordic vectoring
    function automatic longint theta_of(longint dx, longint dy);
        longint x;
        longint y;
        longint ang;
        longint t;
        longint xs;
        longint ys;
        x = dx * 65536;
        y = dy * 113512;
        ang = 0;
        if (y == 0)
            return (dx >= 0) ? 0 : longint'(HUE_PI);
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            ang = 26353589;
        end
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            xs = fshift(x, k);
            ys = fshift(y, k);
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                ang += longint'(atan_val(k));
            end
            else
            begin
                x -= ys;
                y += xs;
                ang -= longint'(atan_val(k));
            end
        end
        if (ang < 0)
            ang = 0;
        if (ang > 52707179)
            ang = 52707179;
        t = (ang + 1024) >>> 11;
        if (t > longint'(HUE_PI))
            t = HUE_PI;
        return t;
    endfunction

    // expected hsi of one pixel
    function automatic hsi_t convert_pixel(pixel_t p);
        hsi_t o;
        longint r;
        longint g;
        longint b;
        longint sum;
        longint mn;
        longint dgb;
        longint th;
        longint base;
        longint sat;
        r = p.r;
        g = p.g;
        b = p.b;
        sum = r + g + b;
        mn = r;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        dgb = (g > b) ? g - b : b - g;
        th = theta_of(2 * r - g - b, dgb);
        o.h = (b > g) ? 16'(longint'(HUE_TWO_PI) - th) : 16'(th);
        base = (sum == 0) ? 0 : 32768 - (3 * mn * 65536 + sum) / (2 * sum);
        sat = base + offset_val;
        if (sat < 0)
            sat = 0;
        if (sat > 32768)
            sat = 32768;
        o.s = 16'(sat);
        o.i = 16'((sum * 65536 + 3 * 255) / (6 * 255));
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // apb write, block idle
    task automatic write_offset(logic [16:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_SAT_OFFSET;
        pwdata = {15'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        offset_val = longint'(signed'(v));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || in_valid || hsi_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // pixel driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (!hold_send && pixel_queue.size() != 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_t p;
                    p = pixel_queue.pop_front();
                    red <= p.r;
                    green <= p.g;
                    blue <= p.b;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // input transfer predicts, output transfer checks
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                hsi_expected.push_back(convert_pixel({red, green, blue}));
            if (out_valid && out_ready)
            begin
                if (hsi_expected.size() == 0)
                    report_mismatch("unexpected transfer", 0, 0);
                else
                begin
                    hsi_t e;
                    e = hsi_expected.pop_front();
                    if (hue !== e.h)
                        report_mismatch("hue", hue, e.h);
                    if (saturation !== e.s)
                        report_mismatch("saturation", saturation, e.s);
                    if (intensity !== e.i)
                        report_mismatch("intensity", intensity, e.i);
                end
            end
        end
    end

    task automatic add_random(int n);
        pixel_t p;
        for (int k = 0; k < n; k++)
        begin
            p = {8'($urandom), 8'($urandom), 8'($urandom)};
            case ($urandom_range(5))
                0: p.g = p.b;
                1: p = {p.r, p.r, p.r};
                2: p.b = p.g + 8'($urandom_range(2));
                3: p.r = 8'($urandom_range(1) ? 255 : 0);
                default: ;
            endcase
            pixel_queue.push_back(p);
        end
    endtask

    // stimulus
    initial
    begin
        logic [16:0] offsets[6];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_fire = 1'b0;
        out_ready = 1'b0;
        red = '0;
        green = '0;
        blue = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        offset_val = 0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner pixels at reset offset
        pixel_queue.push_back({8'd0, 8'd0, 8'd0});
        pixel_queue.push_back({8'd255, 8'd255, 8'd255});
        pixel_queue.push_back({8'd128, 8'd128, 8'd128});
        pixel_queue.push_back({8'd255, 8'd0, 8'd0});
        pixel_queue.push_back({8'd0, 8'd255, 8'd0});
        pixel_queue.push_back({8'd0, 8'd0, 8'd255});
        pixel_queue.push_back({8'd255, 8'd255, 8'd0});
        pixel_queue.push_back({8'd0, 8'd255, 8'd255});
        pixel_queue.push_back({8'd255, 8'd0, 8'd255});
        pixel_queue.push_back({8'd10, 8'd50, 8'd50});
        pixel_queue.push_back({8'd200, 8'd50, 8'd50});
        pixel_queue.push_back({8'd100, 8'd100, 8'd101});
        pixel_queue.push_back({8'd255, 8'd254, 8'd255});
        pixel_queue.push_back({8'd1, 8'd0, 8'd0});
        pixel_queue.push_back({8'd170, 8'd85, 8'd1});
        drain();

        // offset extremes and in-between, with idling phases
        offsets = '{17'h08000, 17'h18000, 17'h1FFFF, 17'h10000, 17'h00123, 17'h00000};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_offset(offsets[ph]);
            pixel_queue.push_back({8'd0, 8'd0, 8'd0});
            pixel_queue.push_back({8'd90, 8'd30, 8'd200});
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            add_random(140);
            // sender waits for the pipeline to empty
            if (ph == 2)
            begin
                while (pixel_queue.size() > 70)
                    @(posedge clk);
                hold_send = 1'b1;
                while (hsi_expected.size() != 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            drain();
        end

        // long run with changing idling
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            add_random(100);
            while (pixel_queue.size() != 0)
                @(posedge clk);
        end
        drain();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/rgbhsi_pkg.sv
sv/rgbhsi_pipe.sv
sv/rgb_to_hsi_with_saturation_offset_unit.sv
sim/rgb_to_hsi_with_saturation_offset_unit_tb.sv
